>>> design/clsr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clsr_pkg
// Constants, control word layout, microcode ROM and modular reduction for
// the combined LCG / shuffle-table random number generator.
// ----------------------------------------------------------------------------
package clsr_pkg;

  localparam int TABLE_DEPTH_DEF = 32;

  localparam logic [30:0] MOD_A    = 31'd2147483563;
  localparam logic [30:0] MOD_B    = 31'd2147483399;
  localparam logic [15:0] MUL_A    = 16'd40014;
  localparam logic [15:0] MUL_B    = 16'd40692;
  localparam logic [30:0] SEED_B   = 31'd123456789;
  localparam logic [30:0] WRAP_ADD = 31'd2147483562;
  localparam logic [31:0] FRAC_CAP = 32'd4294966780;
  // 2^31 mod MOD_A and 2^31 mod MOD_B
  localparam logic [7:0]  C_A      = 8'd85;
  localparam logic [7:0]  C_B      = 8'd249;
  // 2^32 mod MOD_A, for the fraction
  localparam logic [7:0]  FRAC_K   = 8'd170;
  localparam int          WARMUP   = 8;

  localparam int STEP_W = 4;

  localparam logic [STEP_W-1:0] STEP_WAIT      = 4'd0;
  localparam logic [STEP_W-1:0] STEP_SEED_MUL  = 4'd1;
  localparam logic [STEP_W-1:0] STEP_SEED_RED  = 4'd2;
  localparam logic [STEP_W-1:0] STEP_SEED_END  = 4'd3;
  localparam logic [STEP_W-1:0] STEP_DRAW_MUL  = 4'd4;
  localparam logic [STEP_W-1:0] STEP_DRAW_RED  = 4'd5;
  localparam logic [STEP_W-1:0] STEP_DRAW_RD   = 4'd6;
  localparam logic [STEP_W-1:0] STEP_DRAW_MIX  = 4'd7;
  localparam logic [STEP_W-1:0] STEP_FRAC_MUL  = 4'd8;
  localparam logic [STEP_W-1:0] STEP_FRAC_OUT  = 4'd9;

  localparam logic [1:0] COND_NEXT    = 2'd0;
  localparam logic [1:0] COND_WAIT_IN = 2'd1;
  localparam logic [1:0] COND_LOOP    = 2'd2;
  localparam logic [1:0] COND_EMIT    = 2'd3;

  typedef struct packed {
    logic [1:0]        cond;
    logic [STEP_W-1:0] target;
    logic              load_seed;
    logic              mul_a;
    logic              mul_b;
    logic              red_a;
    logic              red_b;
    logic              fill;
    logic              load_lo;
    logic              slot_q0;
    logic              slot_fix;
    logic              rd_tab;
    logic              combine;
    logic              frac_mul;
    logic              frac_out;
  } ctrl_t;

  typedef struct packed {
    logic cnt_nz;
    logic out_busy;
  } dp_stat_t;

  function automatic ctrl_t clsr_rom(input logic [STEP_W-1:0] pc);
    ctrl_t w;
    w = '0;
    case (pc)
      STEP_WAIT: begin
        w.cond      = COND_WAIT_IN;
        w.target    = STEP_DRAW_MUL;
        w.load_seed = 1'b1;
      end
      STEP_SEED_MUL: begin
        w.mul_a = 1'b1;
      end
      STEP_SEED_RED: begin
        w.cond   = COND_LOOP;
        w.target = STEP_SEED_MUL;
        w.red_a  = 1'b1;
        w.fill   = 1'b1;
      end
      STEP_SEED_END: begin
        w.load_lo = 1'b1;
      end
      STEP_DRAW_MUL: begin
        w.mul_a   = 1'b1;
        w.mul_b   = 1'b1;
        w.slot_q0 = 1'b1;
      end
      STEP_DRAW_RED: begin
        w.red_a    = 1'b1;
        w.red_b    = 1'b1;
        w.slot_fix = 1'b1;
      end
      STEP_DRAW_RD: begin
        w.rd_tab = 1'b1;
      end
      STEP_DRAW_MIX: begin
        w.combine = 1'b1;
      end
      STEP_FRAC_MUL: begin
        w.frac_mul = 1'b1;
      end
      STEP_FRAC_OUT: begin
        w.cond     = COND_EMIT;
        w.target   = STEP_WAIT;
        w.frac_out = 1'b1;
      end
      default: begin
        w = '0;
      end
    endcase
    return w;
  endfunction

  // p mod m for m = 2^31 - c, p < 2^47; one conditional subtract suffices
  function automatic logic [30:0] lcg_reduce(input logic [46:0] p,
                                             input logic [7:0]  c,
                                             input logic [30:0] m);
    logic [31:0] s;
    s = {16'd0, p[46:31]} * {24'd0, c} + {1'b0, p[30:0]};
    if (s >= {1'b0, m}) begin
      s = s - {1'b0, m};
    end
    return s[30:0];
  endfunction

endpackage
`default_nettype wire

>>> design/clsr_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clsr_if
// Request and result channels: valid/ready with payload.
// ----------------------------------------------------------------------------
interface clsr_req_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [30:0] seed;
  modport source (output valid, output mode, output seed, input ready);
  modport sink (input valid, input mode, input seed, output ready);
endinterface

interface clsr_rsp_if;
  logic        valid;
  logic        ready;
  logic [30:0] value;
  logic [31:0] fraction;
  modport source (output valid, output value, output fraction, input ready);
  modport sink (input valid, input value, input fraction, output ready);
endinterface
`default_nettype wire

>>> design/clsr_seq.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clsr_seq
// Step counter and microcode ROM; conditional jumps on input, loop count
// and output backpressure.
// ----------------------------------------------------------------------------
module clsr_seq import clsr_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_fire,
  input  logic     in_mode,
  input  dp_stat_t stat,
  output ctrl_t    ctrl
);

  logic [STEP_W-1:0] pc;
  logic [STEP_W-1:0] pc_next;

  always_comb begin
    ctrl = clsr_rom(pc);
  end

  always_comb begin
    pc_next = pc + 1'b1;
    case (ctrl.cond)
      COND_WAIT_IN: begin
        if (!in_fire) begin
          pc_next = pc;
        end else if (!in_mode) begin
          pc_next = ctrl.target;
        end
      end
      COND_LOOP: begin
        if (stat.cnt_nz) begin
          pc_next = ctrl.target;
        end
      end
      COND_EMIT: begin
        pc_next = stat.out_busy ? pc : ctrl.target;
      end
      default: begin
        pc_next = pc + 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= STEP_WAIT;
    end else begin
      pc <= pc_next;
    end
  end

endmodule
`default_nettype wire

>>> design/clsr_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clsr_dp
// Generator registers, shared multiply/reduce units, shuffle table memory,
// slot divider and fraction unit, output register.
// ----------------------------------------------------------------------------
module clsr_dp import clsr_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  ctrl_t       ctrl,
  input  logic        in_fire,
  input  logic        in_mode,
  input  logic [30:0] in_seed,
  output dp_stat_t    stat,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [30:0] out_value,
  output logic [31:0] out_fraction
);

  localparam int     IW         = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int     CW         = $clog2(TABLE_DEPTH + WARMUP);
  localparam longint SLOT_DIV   = 1 + longint'(WRAP_ADD) / TABLE_DEPTH;
  localparam longint SLOT_RECIP = (longint'(1) << 32) / SLOT_DIV;
  localparam int     RW         = $clog2(SLOT_RECIP + 1);
  localparam int     PW         = 31 + RW;

  logic [30:0]       ga;
  logic [30:0]       gb;
  logic [30:0]       lo;
  logic [46:0]       pa;
  logic [46:0]       pb;
  logic [CW-1:0]     n;
  logic [RW-2:0]     q0;
  logic [IW-1:0]     slot;
  logic [30:0]       rd;
  logic              rd_ok;
  logic [38:0]       fy;
  logic [30:0]       tab [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] tab_vld;

  logic [30:0]       ga_red;
  logic [30:0]       gb_red;
  logic [30:0]       seed_f;
  logic [PW-1:0]     prod;
  logic [PW-1:0]     qd;
  logic [PW-1:0]     rem;
  logic [RW-1:0]     q;
  logic [IW-1:0]     slot_next;
  logic [30:0]       rdv;
  logic [32:0]       diff;
  logic [32:0]       wrapped;
  logic [7:0]        yh;
  logic [31:0]       fs;
  logic [32:0]       fr;
  logic [31:0]       frac_next;
  logic              we;
  logic [IW-1:0]     waddr;
  logic [30:0]       wdata;
  logic              emit;

  always_comb begin
    ga_red = lcg_reduce(pa, C_A, MOD_A);
    gb_red = lcg_reduce(pb, C_B, MOD_B);
    seed_f = (in_seed == '0) ? 31'd1 : in_seed;

    // slot = lo / SLOT_DIV via reciprocal, then one correction
    prod = PW'(lo) * PW'(SLOT_RECIP);
    qd   = PW'(q0) * PW'(SLOT_DIV);
    rem  = PW'(lo) - qd;
    q    = RW'(q0) + RW'(rem >= PW'(SLOT_DIV));
    if (32'(q) >= 32'(TABLE_DEPTH)) begin
      slot_next = IW'(TABLE_DEPTH - 1);
    end else begin
      slot_next = IW'(q);
    end

    rdv  = rd_ok ? rd : '0;
    diff = {2'b00, rdv} - {2'b00, gb};
    if (diff[32] || diff == '0) begin
      wrapped = diff + {2'b00, WRAP_ADD};
    end else begin
      wrapped = diff;
    end

    // floor(v*2^32/MOD_A) = 2v + floor(170v/MOD_A)
    yh = fy[38:31];
    fs = {24'd0, yh} * {24'd0, C_A} + {1'b0, fy[30:0]};
    fr = {1'b0, lo, 1'b0} + {25'd0, yh} + {32'd0, fs >= {1'b0, MOD_A}};
    if (fr > {1'b0, FRAC_CAP}) begin
      frac_next = FRAC_CAP;
    end else begin
      frac_next = fr[31:0];
    end

    we    = (ctrl.fill && (n < CW'(TABLE_DEPTH))) || ctrl.combine;
    waddr = ctrl.fill ? n[IW-1:0] : slot;
    wdata = ctrl.fill ? ga_red : ga;

    emit          = ctrl.frac_out && !(out_valid && !out_ready);
    stat.cnt_nz   = (n != '0);
    stat.out_busy = out_valid && !out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ga      <= 31'd1;
      gb      <= SEED_B;
      lo      <= '0;
      tab_vld <= '0;
    end else begin
      if (ctrl.load_seed && in_fire && in_mode) begin
        ga <= seed_f;
        gb <= seed_f;
      end else begin
        if (ctrl.red_a) begin
          ga <= ga_red;
        end
        if (ctrl.red_b) begin
          gb <= gb_red;
        end
      end
      if (ctrl.load_lo) begin
        lo <= ga;
      end else if (ctrl.combine) begin
        lo <= wrapped[30:0];
      end
      if (we) begin
        tab_vld[waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_seed && in_fire && in_mode) begin
      n <= CW'(TABLE_DEPTH + WARMUP - 1);
    end else if (ctrl.fill) begin
      n <= n - 1'b1;
    end
    if (ctrl.mul_a) begin
      pa <= 47'(ga) * 47'(MUL_A);
    end
    if (ctrl.mul_b) begin
      pb <= 47'(gb) * 47'(MUL_B);
    end
    if (ctrl.slot_q0) begin
      q0 <= prod[PW-1:32];
    end
    if (ctrl.slot_fix) begin
      slot <= slot_next;
    end
    if (ctrl.frac_mul) begin
      fy <= 39'(lo) * 39'(FRAC_K);
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      tab[waddr] <= wdata;
    end
    if (ctrl.rd_tab) begin
      rd    <= tab[slot];
      rd_ok <= tab_vld[slot];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_value    <= lo;
      out_fraction <= frac_next;
    end
  end

endmodule
`default_nettype wire

>>> design/combined_lcg_shuffle_rng.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// combined_lcg_shuffle_rng
// Two-generator combined LCG with a shuffle table, run by a microcoded
// sequencer over a shared multiply/reduce datapath.
//
//   channel  dir  payload                          handshake
//   req      in   mode[0], seed[30:0]              valid/ready
//   rsp      out  value[30:0], fraction[31:0]      valid/ready
//
// Draw: one wait step, then six datapath steps per item.
// Reseed: 40 generator steps, each a multiply step and a reduce step through the
// generator A multiply/reduce unit, plus one load step, before the draw.
// Reset loads the generator seeds and clears the table valid bits at once.
// A result held on rsp stalls the final step; the next item is taken while
// the last result waits.
// ----------------------------------------------------------------------------
module combined_lcg_shuffle_rng import clsr_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  clsr_req_if.sink   req,
  clsr_rsp_if.source rsp
);

  ctrl_t    ctrl;
  dp_stat_t stat;
  logic     in_fire;

  assign req.ready = (ctrl.cond == COND_WAIT_IN);
  assign in_fire   = req.valid && req.ready;

  clsr_seq u_seq (
    .clk     (clk),
    .rst     (rst),
    .in_fire (in_fire),
    .in_mode (req.mode),
    .stat    (stat),
    .ctrl    (ctrl)
  );

  clsr_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .in_fire      (in_fire),
    .in_mode      (req.mode),
    .in_seed      (req.seed),
    .stat         (stat),
    .out_valid    (rsp.valid),
    .out_ready    (rsp.ready),
    .out_value    (rsp.value),
    .out_fraction (rsp.fraction)
  );

endmodule
`default_nettype wire
